>>> rtl/core/mgp_pkg.sv
// Shared types and constants for the masked grid prolongation block.
package mgp_pkg;

   localparam int COORD_W = 7;
   localparam int DATA_W  = 32;
   localparam int REG_W   = 7;
   localparam int SUM_W   = DATA_W + 2;

   localparam logic [REG_W-1:0] COARSE_SIZE_RESET = 7'd32;

   // register select is paddr[2]
   localparam logic REG_COARSE_COLS = 1'b0;
   localparam logic REG_COARSE_ROWS = 1'b1;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      KIND_STORE,
      KIND_INTERP,
      KIND_ZERO,
      KIND_FAULT
   } item_kind_type;

   // Classified item. Interpolation always sums (ra,ca)+(ra,cb)+(rb,ca)+(rb,cb)
   // and shifts by two; copies and pair means repeat a row or column.
   typedef struct packed {
      item_kind_type        kind;
      logic [COORD_W-1:0]   ra;
      logic [COORD_W-1:0]   rb;
      logic [COORD_W-1:0]   ca;
      logic [COORD_W-1:0]   cb;
      logic [DATA_W-1:0]    wdata;
   } queue_entry_type;

endpackage

>>> rtl/core/masked_grid_prolongation.sv
// Top level of the masked grid prolongation block.
//
//   port group   direction  handshake               payload
//   req_*        in         start / busy            func, row, col, coarse_value, point_active
//   rsp_*        out        rsp_valid (one cycle)   fine_value, status
//   APB          in/out     psel/penable/pwrite     coarse_cols @0x0, coarse_rows @0x4
//
// One item per cycle. A result passes through the queue slot, which loads at the edge
// that takes its item, then the registered bank read, then the registered sum, before
// it shows on rsp_*. Each item makes one pass through the four parity banks, one
// read or write port each.
// Synchronous reset clears control and sets both size registers to 32; the grid
// itself holds no reset value. rsp_* cannot be stalled and the back end drains one
// item a cycle, so the queue never fills and busy stays low.
module masked_grid_prolongation
   import mgp_pkg::*;
#(
   parameter int MAX_COARSE = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_func,
   input  logic [COORD_W-1:0]        req_row,
   input  logic [COORD_W-1:0]        req_col,
   input  logic signed [DATA_W-1:0]  req_coarse_value,
   input  logic                      req_point_active,
   output logic                      rsp_valid,
   output logic signed [DATA_W-1:0]  rsp_fine_value,
   output logic                      rsp_status,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [2:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   logic            push;
   logic            queue_full;
   logic            pop_valid;
   queue_entry_type push_entry;
   queue_entry_type pop_entry;

   assign busy   = queue_full;
   assign pready = 1'b1;

   mgp_front #(
      .MAX_COARSE (MAX_COARSE)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .queue_full       (queue_full),
      .req_func         (req_func),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_coarse_value (req_coarse_value),
      .req_point_active (req_point_active),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .push             (push),
      .push_entry       (push_entry)
   );

   mgp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   mgp_back #(
      .MAX_COARSE (MAX_COARSE)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (pop_valid),
      .item           (pop_entry),
      .rsp_valid      (rsp_valid),
      .rsp_fine_value (rsp_fine_value),
      .rsp_status     (rsp_status)
   );

endmodule

>>> rtl/core/mgp_front.sv
// Front end: config registers, item accept and classification.
module mgp_front
   import mgp_pkg::*;
#(
   parameter int MAX_COARSE = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      queue_full,
   input  logic                      req_func,
   input  logic [COORD_W-1:0]        req_row,
   input  logic [COORD_W-1:0]        req_col,
   input  logic signed [DATA_W-1:0]  req_coarse_value,
   input  logic                      req_point_active,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [2:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      push,
   output queue_entry_type           push_entry
);

   localparam logic [8:0] MAX_SIZE = 9'(MAX_COARSE);

   logic [REG_W-1:0]   cols_ff, cols_in;
   logic [REG_W-1:0]   rows_ff, rows_in;
   logic [REG_W-1:0]   nc, nr;
   logic [REG_W:0]     twice_nc, twice_nr;
   logic [REG_W:0]     row_w, col_w;
   logic               csr_write;
   logic               last_row, last_col, even_row, even_col;
   logic [COORD_W-1:0] r0, c0, r1, c1, nr_last, nc_last;

   assign csr_write = psel && penable && pwrite;

   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_COARSE_COLS: cols_in = pwdata[REG_W-1:0];
            REG_COARSE_ROWS: rows_in = pwdata[REG_W-1:0];
            default:         cols_in = cols_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COARSE_SIZE_RESET;
         rows_ff <= COARSE_SIZE_RESET;
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
      end
   end

   assign prdata = (paddr[2] == REG_COARSE_ROWS) ? {25'd0, rows_ff} : {25'd0, cols_ff};

   // zero acts as one, anything above the grid acts as the grid size
   always_comb begin
      nc = cols_ff;
      nr = rows_ff;
      if (cols_ff == '0) nc = 7'd1;
      else if ({2'b00, cols_ff} > MAX_SIZE) nc = MAX_SIZE[REG_W-1:0];
      if (rows_ff == '0) nr = 7'd1;
      else if ({2'b00, rows_ff} > MAX_SIZE) nr = MAX_SIZE[REG_W-1:0];
   end

   assign twice_nc = {nc, 1'b0};
   assign twice_nr = {nr, 1'b0};
   assign row_w    = {1'b0, req_row};
   assign col_w    = {1'b0, req_col};
   assign last_row = (row_w == twice_nr - 8'd1);
   assign last_col = (col_w == twice_nc - 8'd1);
   assign even_row = ~req_row[0];
   assign even_col = ~req_col[0];
   assign r0       = {1'b0, req_row[COORD_W-1:1]};
   assign c0       = {1'b0, req_col[COORD_W-1:1]};
   assign r1       = r0 + 7'd1;
   assign c1       = c0 + 7'd1;
   assign nr_last  = nr - 7'd1;
   assign nc_last  = nc - 7'd1;

   always_comb begin
      push_entry       = '0;
      push_entry.wdata = req_coarse_value;
      push_entry.kind  = KIND_FAULT;
      if (!req_func) begin
         if (req_row < nr && req_col < nc) begin
            push_entry.kind = KIND_STORE;
            push_entry.ra   = req_row;
            push_entry.rb   = req_row;
            push_entry.ca   = req_col;
            push_entry.cb   = req_col;
         end
      end else if (row_w < twice_nr && col_w < twice_nc) begin
         push_entry.kind = KIND_INTERP;
         priority if (even_row && even_col) begin
            push_entry.ra = r0;
            push_entry.rb = r0;
            push_entry.ca = c0;
            push_entry.cb = c0;
         end else if (!req_point_active) begin
            push_entry.kind = KIND_ZERO;
         end else if (last_row) begin
            push_entry.ra = nr_last;
            push_entry.rb = nr_last;
            if (even_col || last_col) begin
               push_entry.ca = last_col ? nc_last : c0;
               push_entry.cb = last_col ? nc_last : c0;
            end else begin
               push_entry.ca = c0;
               push_entry.cb = c1;
            end
         end else if (even_row) begin
            push_entry.ra = r0;
            push_entry.rb = r0;
            push_entry.ca = last_col ? nc_last : c0;
            push_entry.cb = last_col ? nc_last : c1;
         end else if (even_col || last_col) begin
            push_entry.ra = r0;
            push_entry.rb = r1;
            push_entry.ca = last_col ? nc_last : c0;
            push_entry.cb = last_col ? nc_last : c0;
         end else begin
            push_entry.ra = r0;
            push_entry.rb = r1;
            push_entry.ca = c0;
            push_entry.cb = c1;
         end
      end
   end

   assign push = start && !queue_full;

endmodule

>>> rtl/core/mgp_queue.sv
// Two-entry item queue between front and back.
module mgp_queue
   import mgp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  queue_entry_type  push_entry,
   output logic             full,
   output logic             pop_valid,
   output queue_entry_type  pop_entry
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   queue_entry_type  slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // back end never stalls, so every held item leaves the next cycle
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slot_ff[rptr_ff];
   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));

   always_comb begin
      wptr_in  = push ? PTR_W'(wptr_ff + 1'b1) : wptr_ff;
      rptr_in  = pop_valid ? PTR_W'(rptr_ff + 1'b1) : rptr_ff;
      count_in = CNT_W'(count_ff + CNT_W'(push) - CNT_W'(pop_valid));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wptr_ff] <= push_entry;
   end

endmodule

>>> rtl/core/mgp_back.sv
// Back end: parity-banked coarse grid, four-word fetch and averaging.
module mgp_back
   import mgp_pkg::*;
#(
   parameter int MAX_COARSE = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      item_valid,
   input  queue_entry_type           item,
   output logic                      rsp_valid,
   output logic signed [DATA_W-1:0]  rsp_fine_value,
   output logic                      rsp_status
);

   localparam int HALF       = (MAX_COARSE + 1) / 2;
   localparam int BANK_DEPTH = HALF * HALF;
   localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   logic [DATA_W-1:0] rdata_ff [4];
   logic              s1_valid_ff;
   item_kind_type     s1_kind_ff;
   logic [3:0]        s1_sel_ff;   // parities of ra, rb, ca, cb

   logic [DATA_W-1:0] w_aa, w_ab, w_ba, w_bb;
   logic [SUM_W-1:0]  sum;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_fine_value_ff, rsp_fine_value_in;
   logic              rsp_status_ff, rsp_status_in;

   // bank {p,q} holds samples with row parity p and column parity q
   for (genvar b = 0; b < 4; b++) begin : g_bank
      localparam logic P = 1'(b >> 1);
      localparam logic Q = 1'(b & 1);

      logic [DATA_W-1:0]  mem [BANK_DEPTH];
      logic [COORD_W-1:0] rsel, csel;
      logic [AW-1:0]      addr;
      logic               we;

      assign rsel = (item.ra[0] == P) ? item.ra : item.rb;
      assign csel = (item.ca[0] == Q) ? item.ca : item.cb;
      assign addr = AW'(int'(rsel[COORD_W-1:1]) * HALF + int'(csel[COORD_W-1:1]));
      assign we   = item_valid && (item.kind == KIND_STORE) &&
                    (item.ra[0] == P) && (item.ca[0] == Q);

      always_ff @(posedge clock) begin
         if (we) mem[addr] <= item.wdata;
         rdata_ff[b] <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= item_valid;
      s1_kind_ff <= item.kind;
      s1_sel_ff  <= {item.ra[0], item.rb[0], item.ca[0], item.cb[0]};
   end

   assign w_aa = rdata_ff[{s1_sel_ff[3], s1_sel_ff[1]}];
   assign w_ab = rdata_ff[{s1_sel_ff[3], s1_sel_ff[0]}];
   assign w_ba = rdata_ff[{s1_sel_ff[2], s1_sel_ff[1]}];
   assign w_bb = rdata_ff[{s1_sel_ff[2], s1_sel_ff[0]}];

   assign sum = {{2{w_aa[DATA_W-1]}}, w_aa} + {{2{w_ab[DATA_W-1]}}, w_ab} +
                {{2{w_ba[DATA_W-1]}}, w_ba} + {{2{w_bb[DATA_W-1]}}, w_bb};

   always_comb begin
      rsp_valid_in      = 1'b0;
      rsp_fine_value_in = '0;
      rsp_status_in     = 1'b0;
      unique case (s1_kind_ff)
         KIND_STORE:  rsp_valid_in = 1'b0;
         KIND_INTERP: begin
            rsp_valid_in      = s1_valid_ff;
            rsp_fine_value_in = sum[SUM_W-1:2];   // floor of sum / 4
         end
         KIND_ZERO:   rsp_valid_in = s1_valid_ff;
         KIND_FAULT: begin
            rsp_valid_in  = s1_valid_ff;
            rsp_status_in = 1'b1;
         end
         default:     rsp_valid_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
      rsp_fine_value_ff <= rsp_fine_value_in;
      rsp_status_ff     <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fine_value = rsp_fine_value_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

>>> tb/mgp_checker.sv
// Scoreboard for masked_grid_prolongation: watches the item, result and APB traffic.
`timescale 1ns / 100ps

package mgp_tb_pkg;

   localparam int GRID_MAX = 64;

   typedef enum logic {
      FUNC_STORE = 1'b0,
      FUNC_FETCH = 1'b1
   } func_type;

   typedef enum logic {
      STATUS_OK    = 1'b0,
      STATUS_RANGE = 1'b1
   } status_type;

endpackage

module mgp_checker
   import mgp_pkg::*;
   import mgp_tb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic                      req_func,
   input  logic [COORD_W-1:0]        req_row,
   input  logic [COORD_W-1:0]        req_col,
   input  logic signed [DATA_W-1:0]  req_coarse_value,
   input  logic                      req_point_active,
   input  logic                      rsp_valid,
   input  logic signed [DATA_W-1:0]  rsp_fine_value,
   input  logic                      rsp_status,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [2:0]                paddr,
   input  logic [31:0]               pwdata,
   input  logic [31:0]               prdata,
   input  logic                      pready,
   output int                        mismatch_count,
   output int                        pending_count,
   output int                        results_checked
);

   typedef struct packed {
      logic signed [DATA_W-1:0] fine_value;
      status_type               status;
   } fine_result_type;

   fine_result_type          pending_results[$];
   logic signed [DATA_W-1:0] coarse_mem [GRID_MAX][GRID_MAX];
   logic [REG_W-1:0]         cols_reg;
   logic [REG_W-1:0]         rows_reg;
   int                       errors = 0;
   int                       seen = 0;

   initial begin
      mismatch_count  = 0;
      pending_count   = 0;
      results_checked = 0;
   end

   function automatic int size_in_use(logic [REG_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > GRID_MAX) return GRID_MAX;
      return int'(raw);
   endfunction

   function automatic longint coarse_word(int r, int c);
      longint w;
      w = longint'(coarse_mem[r % GRID_MAX][c % GRID_MAX]);
      return w;
   endfunction

   function automatic fine_result_type out_of_grid();
      fine_result_type res;
      res.fine_value = '0;
      res.status     = STATUS_RANGE;
      return res;
   endfunction

   // Bilinear prolongation of one fine point; means round toward minus infinity.
   function automatic fine_result_type prolongate(logic [COORD_W-1:0] row,
                                                  logic [COORD_W-1:0] col,
                                                  logic active);
      fine_result_type res;
      int              nr, nc, r0, c0, cc;
      bit              last_r, last_c, even_r, even_c;
      longint          acc;
      nr = size_in_use(rows_reg);
      nc = size_in_use(cols_reg);
      if (row >= 2 * nr || col >= 2 * nc) return out_of_grid();
      last_r = (row == 2 * nr - 1);
      last_c = (col == 2 * nc - 1);
      even_r = !row[0];
      even_c = !col[0];
      r0 = int'(row >> 1);
      c0 = int'(col >> 1);
      if (even_r && even_c) begin
         acc = coarse_word(r0, c0);
      end else if (!active) begin
         acc = 0;
      end else if (last_r) begin
         if (even_c || last_c) acc = coarse_word(nr - 1, last_c ? nc - 1 : c0);
         else acc = (coarse_word(nr - 1, c0) + coarse_word(nr - 1, c0 + 1)) >>> 1;
      end else if (even_r) begin
         if (last_c) acc = coarse_word(r0, nc - 1);
         else acc = (coarse_word(r0, c0) + coarse_word(r0, c0 + 1)) >>> 1;
      end else if (even_c || last_c) begin
         cc  = last_c ? nc - 1 : c0;
         acc = (coarse_word(r0, cc) + coarse_word(r0 + 1, cc)) >>> 1;
      end else begin
         acc = (coarse_word(r0, c0) + coarse_word(r0, c0 + 1) +
                coarse_word(r0 + 1, c0) + coarse_word(r0 + 1, c0 + 1)) >>> 2;
      end
      res.fine_value = acc[DATA_W-1:0];
      res.status     = STATUS_OK;
      return res;
   endfunction

   task automatic flag_mismatch(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
   endtask

   always @(posedge clock) begin
      fine_result_type  want;
      logic [REG_W-1:0] reg_now;
      if (reset) begin
         cols_reg = COARSE_SIZE_RESET;
         rows_reg = COARSE_SIZE_RESET;
         pending_results.delete();
      end else begin
         if (rsp_valid) begin
            seen++;
            if (pending_results.size() == 0) begin
               flag_mismatch($sformatf("result %0d with nothing outstanding: value %h status %0d",
                                       seen, rsp_fine_value, rsp_status));
            end else begin
               want = pending_results.pop_front();
               if (rsp_fine_value !== want.fine_value || rsp_status !== want.status)
                  flag_mismatch($sformatf(
                     "result %0d: expected value %h status %0d, got value %h status %0d",
                     seen, want.fine_value, want.status, rsp_fine_value, rsp_status));
            end
         end

         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr[2] == REG_COARSE_COLS) cols_reg = pwdata[REG_W-1:0];
               else rows_reg = pwdata[REG_W-1:0];
            end else begin
               reg_now = (paddr[2] == REG_COARSE_ROWS) ? rows_reg : cols_reg;
               if (prdata !== {{(32-REG_W){1'b0}}, reg_now})
                  flag_mismatch($sformatf("register read at %h: expected %h, got %h",
                                          paddr, reg_now, prdata));
            end
         end

         if (start && !busy) begin
            if (req_func == FUNC_STORE) begin
               if (req_row >= size_in_use(rows_reg) || req_col >= size_in_use(cols_reg))
                  pending_results.push_back(out_of_grid());
               else
                  coarse_mem[req_row][req_col] = req_coarse_value;
            end else begin
               pending_results.push_back(prolongate(req_row, req_col, req_point_active));
            end
         end
      end
      pending_count   <= pending_results.size();
      mismatch_count  <= errors;
      results_checked <= seen;
   end

endmodule

>>> tb/tb_masked_grid_prolongation.sv
// Stimulus and verdict for masked_grid_prolongation.
`timescale 1ns / 100ps

module tb_masked_grid_prolongation;
   import mgp_pkg::*;
   import mgp_tb_pkg::*;

   localparam int LATENCY     = 3;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 185;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_func;
   logic [COORD_W-1:0]        req_row;
   logic [COORD_W-1:0]        req_col;
   logic signed [DATA_W-1:0]  req_coarse_value;
   logic                      req_point_active;
   logic                      rsp_valid;
   logic signed [DATA_W-1:0]  rsp_fine_value;
   logic                      rsp_status;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [2:0]                paddr;
   logic [31:0]               pwdata;
   logic [31:0]               prdata;
   logic                      pready;
   int                        mismatch_count;
   int                        pending_count;
   int                        results_checked;

   // negative entries pick a random small size
   int  cols_plan [PHASES] = '{1, 0, 64, 5, 127, 3, 65, -1, 2, 64};
   int  rows_plan [PHASES] = '{1, 127, 64, 3, 0, 7, 2, -1, 64, 1};
   bit  stored [GRID_MAX][GRID_MAX];
   int  cur_nc, cur_nr, idle_pct;
   int  items_sent, reads_sent, stores_sent, settings_used;

   masked_grid_prolongation u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_coarse_value (req_coarse_value),
      .req_point_active (req_point_active),
      .rsp_valid        (rsp_valid),
      .rsp_fine_value   (rsp_fine_value),
      .rsp_status       (rsp_status),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   mgp_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_coarse_value (req_coarse_value),
      .req_point_active (req_point_active),
      .rsp_valid        (rsp_valid),
      .rsp_fine_value   (rsp_fine_value),
      .rsp_status       (rsp_status),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count),
      .results_checked  (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("** masked_grid_prolongation: FAILED **");
      $finish;
   end

   function automatic int size_in_use(logic [REG_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > GRID_MAX) return GRID_MAX;
      return int'(raw);
   endfunction

   // edge-biased index in 0..n-1
   function automatic int pick_index(int n);
      case ($urandom_range(7))
         0: return 0;
         1: return n - 1;
         2: return (n > 1) ? n - 2 : 0;
         default: return $urandom_range(n - 1);
      endcase
   endfunction

   function automatic logic [31:0] rand_sample();
      case ($urandom_range(7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         4: return $urandom_range(255);
         5: return -$urandom_range(255);
         default: return $urandom();
      endcase
   endfunction

   // All tasks start and end right after a rising edge.
   task automatic send_item(func_type f, int r, int c, logic [31:0] v, logic act);
      // each cycle idles with probability idle_pct percent
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_func         <= f;
      req_row          <= r[COORD_W-1:0];
      req_col          <= c[COORD_W-1:0];
      req_coarse_value <= v;
      req_point_active <= act;
      do @(posedge clock); while (busy);
      items_sent++;
      if (f == FUNC_FETCH) begin
         reads_sent++;
      end else begin
         stores_sent++;
         if (r < cur_nr && c < cur_nc) stored[r][c] = 1'b1;
      end
   endtask

   // Reads only ever touch samples that hold a written value.
   task automatic fetch_point(int r, int c, logic act);
      int rs [2];
      int cs [2];
      if (r < 2 * cur_nr && c < 2 * cur_nc && (act || (r % 2 == 0 && c % 2 == 0))) begin
         rs[0] = r >> 1;
         cs[0] = c >> 1;
         rs[1] = (rs[0] + 1 < cur_nr) ? rs[0] + 1 : cur_nr - 1;
         cs[1] = (cs[0] + 1 < cur_nc) ? cs[0] + 1 : cur_nc - 1;
         foreach (rs[i])
            foreach (cs[j])
               if (!stored[rs[i]][cs[j]])
                  send_item(FUNC_STORE, rs[i], cs[j], rand_sample(), $urandom_range(1));
      end
      send_item(FUNC_FETCH, r, c, $urandom(), act);
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 3) @(posedge clock);
   endtask

   task automatic csr_access(logic wr, logic reg_sel, logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_grid(int cols_raw, int rows_raw);
      drain();
      csr_access(1'b1, REG_COARSE_COLS, ($urandom() & 32'hFFFF_FF80) | cols_raw);
      csr_access(1'b1, REG_COARSE_ROWS, ($urandom() & 32'hFFFF_FF80) | rows_raw);
      csr_access(1'b0, REG_COARSE_COLS, 32'h0);
      csr_access(1'b0, REG_COARSE_ROWS, 32'h0);
      cur_nc = size_in_use(cols_raw[REG_W-1:0]);
      cur_nr = size_in_use(rows_raw[REG_W-1:0]);
      settings_used++;
   endtask

   task automatic run_phase(int quota);
      int base, r, c, pick;
      bit act, row_out, halfway_done;
      base = items_sent;
      halfway_done = 0;
      while (items_sent - base < quota) begin
         // hold off once mid-phase until every result is back
         if (!halfway_done && items_sent - base >= quota / 2) begin
            drain();
            halfway_done = 1;
         end
         pick = $urandom_range(99);
         act  = ($urandom_range(9) != 0);
         if (pick < 55) begin
            fetch_point(pick_index(2 * cur_nr), pick_index(2 * cur_nc), act);
         end else if (pick < 75) begin
            send_item(FUNC_STORE, pick_index(cur_nr), pick_index(cur_nc), rand_sample(), act);
         end else if (pick < 85 && (2 * cur_nr < 128 || 2 * cur_nc < 128)) begin
            row_out = (2 * cur_nr < 128) && (2 * cur_nc >= 128 || $urandom_range(1) == 1);
            r = row_out ? $urandom_range(127, 2 * cur_nr) : $urandom_range(127);
            c = row_out ? $urandom_range(127) : $urandom_range(127, 2 * cur_nc);
            fetch_point(r, c, act);
         end else if (pick < 92) begin
            row_out = $urandom_range(1);
            r = row_out ? $urandom_range(127, cur_nr) : pick_index(cur_nr);
            c = row_out ? pick_index(cur_nc) : $urandom_range(127, cur_nc);
            send_item(FUNC_STORE, r, c, rand_sample(), act);
         end else begin
            r = $urandom_range(127);
            c = $urandom_range(127);
            if ($urandom_range(1)) fetch_point(r, c, act);
            else send_item(FUNC_STORE, r, c, $urandom(), act);
         end
      end
   endtask

   initial begin
      int ph;
      reset            = 1'b1;
      start            = 1'b0;
      req_func         = FUNC_STORE;
      req_row          = '0;
      req_col          = '0;
      req_coarse_value = '0;
      req_point_active = 1'b0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      cur_nc           = int'(COARSE_SIZE_RESET);
      cur_nr           = int'(COARSE_SIZE_RESET);
      idle_pct         = 26;
      items_sent       = 0;
      reads_sent       = 0;
      stores_sent      = 0;
      settings_used    = 1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset grid size: far corner and a store just past it
      send_item(FUNC_STORE, 31, 31, 32'h0001_8000, 1'b0);
      fetch_point(63, 63, 1'b1);
      send_item(FUNC_STORE, 32, 0, 32'h1234_5678, 1'b1);

      // 2x2 coarse grid: extreme samples, every interpolation shape
      set_grid(2, 2);
      send_item(FUNC_STORE, 0, 0, 32'h7FFF_FFFF, 1'b0);
      send_item(FUNC_STORE, 0, 1, 32'h7FFF_FFFF, 1'b1);
      send_item(FUNC_STORE, 1, 0, 32'h8000_0000, 1'b0);
      send_item(FUNC_STORE, 1, 1, 32'hFFFF_FFFF, 1'b1);
      send_item(FUNC_STORE, 2, 0, 32'hDEAD_BEEF, 1'b1);
      send_item(FUNC_STORE, 0, 127, 32'h0000_0001, 1'b0);
      fetch_point(0, 0, 1'b0);
      fetch_point(0, 1, 1'b1);
      fetch_point(0, 1, 1'b0);
      fetch_point(1, 0, 1'b1);
      fetch_point(1, 1, 1'b1);
      fetch_point(1, 1, 1'b0);
      fetch_point(2, 2, 1'b1);
      fetch_point(3, 3, 1'b1);
      fetch_point(3, 0, 1'b1);
      fetch_point(3, 1, 1'b1);
      fetch_point(0, 3, 1'b1);
      fetch_point(1, 3, 1'b1);
      fetch_point(4, 0, 1'b1);
      fetch_point(127, 127, 1'b1);

      for (ph = 0; ph < PHASES; ph++) begin
         idle_pct = (ph < 3) ? 26 : (ph < 6) ? 71 : 0;
         set_grid(cols_plan[ph] < 0 ? int'($urandom_range(12, 1)) : cols_plan[ph],
                  rows_plan[ph] < 0 ? int'($urandom_range(12, 1)) : rows_plan[ph]);
         run_phase(PHASE_ITEMS);
      end

      drain();
      $display("Run: %0d items (%0d reads, %0d stores), %0d results checked, %0d grid sizes,",
               items_sent, reads_sent, stores_sent, results_checked, settings_used);
      $display("     single row/column through 64x64, raw sizes 0 and 127, idle and back-to-back.");
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("** masked_grid_prolongation: PASSED **");
      end else begin
         if (pending_count != 0) $display("%0d expected results never arrived", pending_count);
         $display("%0d mismatches", mismatch_count);
         $display("** masked_grid_prolongation: FAILED **");
      end
      $finish;
   end

endmodule
